@@ sv/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, codes and the sort key for the layered depth sort queue.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int unsigned SpriteW = 16;
	localparam int unsigned LayerW  = 3;
	localparam int unsigned PosW    = 16;
	localparam int unsigned KeyW    = LayerW + PosW;
	localparam int unsigned StatusW = 2;

	typedef enum logic [StatusW-1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_OFFSET_X = 1'b0,
		REG_OFFSET_Y = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PosW-1:0]    pos_y;
		logic [PosW-1:0]    pos_x;
		logic [LayerW-1:0]  layer;
		logic [SpriteW-1:0] sprite_id;
	} entry_t;

	// broadcast from the head of the row to every cell
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t item;
	} cell_ctl_t;

	// layer above y, sign bit of y flipped so the unsigned compare orders it
	function automatic logic [KeyW-1:0] sort_key(input entry_t e);
		sort_key = {e.layer, ~e.pos_y[PosW-1], e.pos_y[PosW-2:0]};
	endfunction

endpackage

@@ sv/layered_depth_sort_queue.sv @@
// ----------------------------------------------------------------------------
// layered_depth_sort_queue
// Sorted queue of draw entries built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one command word per handshake: s_tuser is the command
//   (insert or pop), s_tdata carries the entry. Entries stay ordered by
//   layer, then signed y; equal keys keep arrival order.
//   m_* gives exactly one result word per command: m_tuser is the status,
//   m_tdata the popped entry with the screen offsets added, m_tlast set
//   when a pop empties the queue.
//   Every cell compares its entry with the incoming item at once, so an
//   insert or pop needs no second pass: a command is accepted in any cycle
//   the output register is free or being drained, and its result appears
//   in the next cycle. Unstalled, the sustained rate is one command per cycle.
//   A stall on m_tready holds the result and backs up s_tready.
//   Reset empties the queue and clears both offsets; there is no clearing
//   pass, since a cell is only read while it counts as occupied.
//   The offsets are written through the APB port at 0x0 and 0x4.
// ----------------------------------------------------------------------------
module layered_depth_sort_queue #(
	parameter int unsigned QUEUE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // sprite_id, layer, pos_x, pos_y, zero pad
	input  logic        s_tuser,  // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_sprite_id, out_layer, screen_x, screen_y, zero pad
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);
	import lds_pkg::*;

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EntW = $bits(entry_t);

	// configuration
	logic [PosW-1:0] offset_x_q, offset_y_q;
	reg_idx_t        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_OFFSET_X: offset_x_q <= pwdata[PosW-1:0];
				REG_OFFSET_Y: offset_y_q <= pwdata[PosW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_OFFSET_X: prdata = {{(32-PosW){1'b0}}, offset_x_q};
			REG_OFFSET_Y: prdata = {{(32-PosW){1'b0}}, offset_y_q};
			default:      prdata = '0;
		endcase
	end

	// command decode
	logic      accept;
	cmd_t      cmd;
	entry_t    item;
	logic      full, empty;
	logic [CntW-1:0] count_q;
	cell_ctl_t ctl;

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign item     = entry_t'(s_tdata[EntW-1:0]);
	assign full     = (count_q == CntW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	assign ctl.ins  = accept && (cmd == CMD_INSERT) && !full;
	assign ctl.pop  = accept && (cmd == CMD_POP) && !empty;
	assign ctl.item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// row of cells
	entry_t cell_entry [QUEUE_DEPTH];
	logic   cell_gt    [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CntW-1:0] Idx = CntW'(i);
		logic   left_gt;
		entry_t left_entry, right_entry;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_entry = cell_entry[i];
		end else begin : g_mid
			assign left_gt    = cell_gt[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		lds_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (Idx < count_q),
			.tail        (Idx == count_q),
			.left_gt     (left_gt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.gt          (cell_gt[i]),
			.entry       (cell_entry[i])
		);
	end

	// result register
	status_t         status_q;
	logic [SpriteW-1:0] sprite_q;
	logic [LayerW-1:0]  layer_q;
	logic [PosW-1:0]    sx_q, sy_q;
	logic               last_q;
	logic               m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sprite_q <= '0;
			layer_q  <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			last_q   <= 1'b0;
			priority if (cmd == CMD_INSERT) begin
				status_q <= full ? ST_DROPPED : ST_INSERTED;
			end else if (empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_POPPED;
				sprite_q <= cell_entry[0].sprite_id;
				layer_q  <= cell_entry[0].layer;
				sx_q     <= cell_entry[0].pos_x + offset_x_q;
				sy_q     <= cell_entry[0].pos_y + offset_y_q;
				last_q   <= (count_q == CntW'(1));
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(56-EntW){1'b0}}, sy_q, sx_q, layer_q, sprite_q};

endmodule

@@ sv/lds_cell.sv @@
// ----------------------------------------------------------------------------
// lds_cell
// One slot of the sorted row: compares its entry against the broadcast
// item and shifts, loads or holds.
// ----------------------------------------------------------------------------
module lds_cell (
	input  logic              clk,
	input  lds_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic              tail,
	input  logic              left_gt,
	input  lds_pkg::entry_t   left_entry,
	input  lds_pkg::entry_t   right_entry,
	output logic              gt,
	output lds_pkg::entry_t   entry
);
	import lds_pkg::*;

	entry_t entry_q;

	// stored key strictly greater: new item goes in front of this one
	assign gt    = occ && (sort_key(entry_q) > sort_key(ctl.item));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt || tail) begin
				entry_q <= ctl.item;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ sv/lds_checker.sv @@
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks for the layered depth sort queue, bound to the top.
// ----------------------------------------------------------------------------
module lds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import lds_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// every accepted command gives a result the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted command produced no result");

	// only a pop can mark the queue empty
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == ST_POPPED)
		else $error("last set on a non-pop result");

	// results other than a pop carry no entry
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_POPPED |-> m_tdata == '0 && !m_tlast)
		else $error("non-pop result carries data");

	// no new command while a stalled result is pending
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("command accepted over a stalled result");

endmodule

bind layered_depth_sort_queue lds_checker u_lds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
